>>> design/acc_cpu_pkg.sv
// acc_cpu_pkg: shared types, opcodes and microcode ROM for the accumulator CPU core.
// No dependencies; imported by every module in the design folder except acc_cpu_ram.
package acc_cpu_pkg;

  localparam int MEM_DEPTH = 256;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] count_t;

  // Command codes on the command channel
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_EXEC    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RS_RUN  = 2'd0,
    RS_HALT = 2'd1,
    RS_BAD  = 2'd2
  } run_t;

  // Opcodes, exact byte match
  localparam byte_t OPC_NOP = 8'h00;
  localparam byte_t OPC_STA = 8'h10;
  localparam byte_t OPC_LDA = 8'h20;
  localparam byte_t OPC_ADD = 8'h30;
  localparam byte_t OPC_OR  = 8'h40;
  localparam byte_t OPC_AND = 8'h50;
  localparam byte_t OPC_NOT = 8'h60;
  localparam byte_t OPC_JMP = 8'h80;
  localparam byte_t OPC_JN  = 8'h90;
  localparam byte_t OPC_JZ  = 8'hA0;
  localparam byte_t OPC_HLT = 8'hF0;

  typedef struct packed {
    op_t   operation;
    byte_t address;
    byte_t data;
  } cmd_word_t;

  typedef struct packed {
    byte_t  accumulator;
    byte_t  program_counter;
    logic   negative_flag;
    logic   zero_flag;
    run_t   run_status;
    byte_t  read_data;
    count_t access_count;
    count_t instruction_count;
  } res_word_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_REPORT
  } seq_state_t;

  // Microcode addresses
  typedef enum logic [4:0] {
    U_WRITE,
    U_READ,
    U_READ_LATCH,
    U_RESTART,
    U_IDLE,
    U_FETCH,
    U_DECODE,
    U_NOT,
    U_HALT,
    U_BAD,
    U_OPADDR,
    U_JMP,
    U_JN,
    U_JZ,
    U_STA,
    U_LDA_RD,
    U_LDA_WB,
    U_ADD_RD,
    U_ADD_WB,
    U_OR_RD,
    U_OR_WB,
    U_AND_RD,
    U_AND_WB
  } upc_t;

  typedef enum logic [1:0] {
    AS_PC,
    AS_CMD,
    AS_BYTE
  } addr_sel_t;

  typedef enum logic {
    WD_CMD,
    WD_ACC
  } wd_sel_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NEG,
    JC_ZERO
  } jmp_cond_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_LDA,
    ALU_ADD,
    ALU_OR,
    ALU_AND,
    ALU_NOT
  } alu_op_t;

  typedef enum logic [1:0] {
    NX_SEQ,   // fall through to next address
    NX_END,   // item done
    NX_OPC,   // dispatch on fetched opcode
    NX_IR     // dispatch on latched instruction
  } next_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    wd_sel_t   wd_sel;
    logic      pc_inc;
    jmp_cond_t jmp;
    logic      acnt_inc;
    logic      icnt_inc;
    logic      ir_load;
    logic      rd_load;
    alu_op_t   alu;
    logic      stop_load;
    run_t      stop_code;
    logic      clear;
    next_t     nx;
  } ucw_t;

  typedef struct packed {
    logic start;  // command accepted this cycle
    logic step;   // control word below is live
    ucw_t cw;
  } dp_ctrl_t;

  typedef struct packed {
    byte_t mem_byte;
    byte_t ir;
    logic  running;
  } dp_status_t;

  // Control store
  function automatic ucw_t ucode(upc_t a);
    ucw_t w;
    w = '0;
    unique case (a)
      U_WRITE: begin
        w.addr_sel = AS_CMD; w.mem_wr = 1'b1; w.wd_sel = WD_CMD; w.nx = NX_END;
      end
      U_READ: begin
        w.addr_sel = AS_CMD; w.mem_rd = 1'b1; w.nx = NX_SEQ;
      end
      U_READ_LATCH: begin
        w.rd_load = 1'b1; w.nx = NX_END;
      end
      U_RESTART: begin
        w.clear = 1'b1; w.nx = NX_END;
      end
      U_IDLE: begin
        w.nx = NX_END;
      end
      U_FETCH: begin
        w.addr_sel = AS_PC; w.mem_rd = 1'b1; w.pc_inc = 1'b1;
        w.acnt_inc = 1'b1; w.icnt_inc = 1'b1; w.nx = NX_SEQ;
      end
      U_DECODE: begin
        w.ir_load = 1'b1; w.nx = NX_OPC;
      end
      U_NOT: begin
        w.alu = ALU_NOT; w.nx = NX_END;
      end
      U_HALT: begin
        w.stop_load = 1'b1; w.stop_code = RS_HALT; w.nx = NX_END;
      end
      U_BAD: begin
        w.stop_load = 1'b1; w.stop_code = RS_BAD; w.nx = NX_END;
      end
      U_OPADDR: begin
        w.addr_sel = AS_PC; w.mem_rd = 1'b1; w.pc_inc = 1'b1;
        w.acnt_inc = 1'b1; w.nx = NX_IR;
      end
      U_JMP: begin
        w.jmp = JC_ALWAYS; w.nx = NX_END;
      end
      U_JN: begin
        w.jmp = JC_NEG; w.nx = NX_END;
      end
      U_JZ: begin
        w.jmp = JC_ZERO; w.nx = NX_END;
      end
      U_STA: begin
        w.addr_sel = AS_BYTE; w.mem_wr = 1'b1; w.wd_sel = WD_ACC;
        w.acnt_inc = 1'b1; w.nx = NX_END;
      end
      U_LDA_RD, U_ADD_RD, U_OR_RD, U_AND_RD: begin
        w.addr_sel = AS_BYTE; w.mem_rd = 1'b1; w.acnt_inc = 1'b1; w.nx = NX_SEQ;
      end
      U_LDA_WB: begin
        w.alu = ALU_LDA; w.nx = NX_END;
      end
      U_ADD_WB: begin
        w.alu = ALU_ADD; w.nx = NX_END;
      end
      U_OR_WB: begin
        w.alu = ALU_OR; w.nx = NX_END;
      end
      U_AND_WB: begin
        w.alu = ALU_AND; w.nx = NX_END;
      end
      default: begin
        w.nx = NX_END;
      end
    endcase
    return w;
  endfunction

  // Dispatch after opcode fetch
  function automatic upc_t opc_target(byte_t opc);
    upc_t t;
    unique case (opc)
      OPC_NOP: t = U_IDLE;
      OPC_NOT: t = U_NOT;
      OPC_HLT: t = U_HALT;
      OPC_STA, OPC_LDA, OPC_ADD, OPC_OR, OPC_AND,
      OPC_JMP, OPC_JN, OPC_JZ: t = U_OPADDR;
      default: t = U_BAD;
    endcase
    return t;
  endfunction

  // Dispatch after operand address fetch
  function automatic upc_t ir_target(byte_t ir);
    upc_t t;
    unique case (ir)
      OPC_STA: t = U_STA;
      OPC_LDA: t = U_LDA_RD;
      OPC_ADD: t = U_ADD_RD;
      OPC_OR:  t = U_OR_RD;
      OPC_AND: t = U_AND_RD;
      OPC_JMP: t = U_JMP;
      OPC_JN:  t = U_JN;
      OPC_JZ:  t = U_JZ;
      default: t = U_IDLE;
    endcase
    return t;
  endfunction

endpackage

>>> design/acc_cpu_ram.sv
// acc_cpu_ram: generic single-port RAM, registered read.
// No dependencies.
module acc_cpu_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/acc_cpu_dp.sv
// acc_cpu_dp: datapath - architectural registers, ALU, counters, main memory.
// Depends on acc_cpu_pkg and acc_cpu_ram.
module acc_cpu_dp #(
  parameter int MemDepth = acc_cpu_pkg::MEM_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  acc_cpu_pkg::cmd_word_t cmd,
  input  acc_cpu_pkg::dp_ctrl_t  ctrl,
  output acc_cpu_pkg::dp_status_t status,
  output acc_cpu_pkg::res_word_t view
);
  import acc_cpu_pkg::*;

  localparam int AddrW = $clog2(MemDepth);

  byte_t     acc;
  byte_t     pc;
  logic      neg;
  logic      zero;
  run_t      stop;
  count_t    acnt;
  count_t    icnt;
  byte_t     rd;
  byte_t     ir;
  cmd_word_t cmd_q;
  logic      valid_q;
  logic [MemDepth-1:0] mem_valid;

  ucw_t             cw;
  byte_t            ram_q;
  byte_t            mem_byte;
  byte_t            sel_addr;
  logic [AddrW-1:0] mem_addr;
  byte_t            wdata;
  logic             re;
  logic             we;
  byte_t            acc_new;
  logic             take_jump;

  assign cw = ctrl.cw;

  // never-written bytes read as zero
  assign mem_byte = valid_q ? ram_q : '0;

  always_comb begin
    unique case (cw.addr_sel)
      AS_PC:   sel_addr = pc;
      AS_CMD:  sel_addr = cmd_q.address;
      AS_BYTE: sel_addr = mem_byte;
      default: sel_addr = pc;
    endcase
  end

  assign mem_addr = sel_addr[AddrW-1:0];
  assign wdata    = (cw.wd_sel == WD_ACC) ? acc : cmd_q.data;
  assign re       = ctrl.step & cw.mem_rd;
  assign we       = ctrl.step & cw.mem_wr;

  always_comb begin
    unique case (cw.alu)
      ALU_LDA: acc_new = mem_byte;
      ALU_ADD: acc_new = byte_t'(acc + mem_byte);
      ALU_OR:  acc_new = acc | mem_byte;
      ALU_AND: acc_new = acc & mem_byte;
      ALU_NOT: acc_new = ~acc;
      default: acc_new = acc;
    endcase
  end

  always_comb begin
    unique case (cw.jmp)
      JC_NONE:   take_jump = 1'b0;
      JC_ALWAYS: take_jump = 1'b1;
      JC_NEG:    take_jump = neg;
      JC_ZERO:   take_jump = zero;
    endcase
  end

  acc_cpu_ram #(
    .Width ($bits(byte_t)),
    .Depth (MemDepth)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (mem_addr),
    .wdata (wdata),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pc        <= '0;
      neg       <= 1'b0;
      zero      <= 1'b0;
      stop      <= RS_RUN;
      acnt      <= '0;
      icnt      <= '0;
      rd        <= '0;
      mem_valid <= '0;
    end else begin
      if (ctrl.start) begin
        rd <= '0;
      end
      if (ctrl.step) begin
        if (cw.clear) begin
          acc  <= '0;
          pc   <= '0;
          neg  <= 1'b0;
          zero <= 1'b0;
          stop <= RS_RUN;
          acnt <= '0;
          icnt <= '0;
        end else begin
          if (take_jump) begin
            pc <= mem_byte;
          end else if (cw.pc_inc) begin
            pc <= byte_t'(pc + 8'd1);
          end
          if (cw.acnt_inc) begin
            acnt <= acnt + 32'd1;
          end
          if (cw.icnt_inc) begin
            icnt <= icnt + 32'd1;
          end
          if (cw.alu != ALU_NONE) begin
            acc  <= acc_new;
            neg  <= acc_new[7];
            zero <= (acc_new == '0);
          end
          if (cw.stop_load) begin
            stop <= cw.stop_code;
          end
          if (cw.rd_load) begin
            rd <= mem_byte;
          end
        end
        if (we) begin
          mem_valid[mem_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cmd_q <= cmd;
    end
    if (ctrl.step && cw.ir_load) begin
      ir <= mem_byte;
    end
    if (re) begin
      valid_q <= mem_valid[mem_addr];
    end
  end

  assign status.mem_byte = mem_byte;
  assign status.ir       = ir;
  assign status.running  = (stop == RS_RUN);

  assign view.accumulator       = acc;
  assign view.program_counter   = pc;
  assign view.negative_flag     = neg;
  assign view.zero_flag         = zero;
  assign view.run_status        = stop;
  assign view.read_data         = rd;
  assign view.access_count      = acnt;
  assign view.instruction_count = icnt;

endmodule

>>> design/acc_cpu_useq.sv
// acc_cpu_useq: microsequencer - command entry, micro-PC, dispatch, result hand-off.
// Depends on acc_cpu_pkg (control store and dispatch functions).
module acc_cpu_useq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  acc_cpu_pkg::cmd_word_t  cmd,
  input  logic                    res_free,
  output logic                    res_load,
  input  acc_cpu_pkg::dp_status_t status,
  output acc_cpu_pkg::dp_ctrl_t   ctrl
);
  import acc_cpu_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  upc_t       upc;
  upc_t       upc_next;
  ucw_t       cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      upc   <= U_IDLE;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

  always_comb begin
    cw         = ucode(upc);
    state_next = state;
    upc_next   = upc;
    ctrl.start = 1'b0;
    ctrl.step  = 1'b0;
    ctrl.cw    = cw;
    cmd_stall  = 1'b1;
    res_load   = 1'b0;
    unique case (state)
      SQ_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctrl.start = 1'b1;
          state_next = SQ_RUN;
          unique case (cmd.operation)
            OP_WRITE:   upc_next = U_WRITE;
            OP_READ:    upc_next = U_READ;
            OP_EXEC:    upc_next = status.running ? U_FETCH : U_IDLE;
            OP_RESTART: upc_next = U_RESTART;
          endcase
        end
      end
      SQ_RUN: begin
        ctrl.step = 1'b1;
        unique case (cw.nx)
          NX_SEQ: upc_next = upc_t'(upc + 5'd1);
          NX_OPC: upc_next = opc_target(status.mem_byte);
          NX_IR:  upc_next = ir_target(status.ir);
          NX_END: state_next = SQ_REPORT;
        endcase
      end
      SQ_REPORT: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = SQ_IDLE;
        end
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

endmodule

>>> design/accumulator_cpu_core.sv
// accumulator_cpu_core: top level of the 8-bit accumulator CPU core.
// Depends on acc_cpu_pkg, acc_cpu_useq, acc_cpu_dp (which holds acc_cpu_ram).
//
// Usage:
// - Command channel (cmd_valid / cmd_stall / cmd): one word per command:
//   write a memory byte, read a memory byte, execute one instruction, or
//   restart the core (memory is kept).
// - Result channel (res_valid / res_stall / res): exactly one word per
//   command, showing the core state after it; read_data is nonzero only
//   for a read.
// - One command at a time. A command runs as a microprogram, one control
//   word per cycle, every memory access a step through the single-port
//   synchronous RAM; an execute while the core is stopped only reports.
//   res_valid rises from the result register, which the report state
//   loads after the last microstep.
// - A stalled result holds; the finished command then waits before the
//   result register and cmd_stall stays high until the result moves.
// - Reset clears registers, counters, status and memory (unwritten bytes
//   read as zero); no clearing pass, the core takes commands right away.
module accumulator_cpu_core #(
  parameter int MemDepth = acc_cpu_pkg::MEM_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  acc_cpu_pkg::cmd_word_t cmd,
  output logic                   res_valid,
  input  logic                   res_stall,
  output acc_cpu_pkg::res_word_t res
);
  import acc_cpu_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;
  res_word_t  view;
  logic       res_free;
  logic       res_load;

  // result register can take a new word when empty or being drained
  assign res_free = !res_valid || !res_stall;

  acc_cpu_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_free  (res_free),
    .res_load  (res_load),
    .status    (status),
    .ctrl      (ctrl)
  );

  acc_cpu_dp #(
    .MemDepth (MemDepth)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .status (status),
    .view   (view)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= view;
    end
  end

`ifndef SYNTHESIS
  // an accepted command keeps the core busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("core not busy after accepting a command");

  // with no command in flight the architectural state does not move
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !cmd_stall && !cmd_valid |=> $stable(view))
    else $error("state changed while idle");

  // a fresh result appears only once the core is idle and matches its state
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !cmd_stall && (res == view))
    else $error("result word does not match core state");
`endif

endmodule
